[hdl/sb2seg_pkg.sv]
// Shared types and constants for the signed binary to seven-segment decoder.
// Holds the BCD cell control word and the digit to segment table; no dependencies.
`default_nettype none

package sb2seg_pkg;

   localparam int DIGIT_BITS = 4;
   localparam int SEG_BITS   = 7;
   localparam int INDEX_BITS = 4;
   localparam int RSP_BITS   = 16;
   localparam int USER_BITS  = 2;

   typedef logic [DIGIT_BITS-1:0] digit_type;
   typedef logic [SEG_BITS-1:0]   seg_type;

   typedef struct packed {
      logic clear;
      logic dabble;
      logic shift_digit;
   } cell_ctrl_type;

   function automatic seg_type seg_of_digit(input digit_type d);
      seg_type s;
      unique case (d)
         4'd0:    s = 7'h3F;
         4'd1:    s = 7'h06;
         4'd2:    s = 7'h5B;
         4'd3:    s = 7'h4F;
         4'd4:    s = 7'h66;
         4'd5:    s = 7'h6D;
         4'd6:    s = 7'h7D;
         4'd7:    s = 7'h07;
         4'd8:    s = 7'h7F;
         4'd9:    s = 7'h6F;
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

[hdl/sb2seg_cell.sv]
// One BCD digit cell of the double dabble chain.
// Shifts a bit in from below per conversion step, or a whole digit upward on readout; uses sb2seg_pkg.
`default_nettype none

module sb2seg_cell (
   input  wire logic                      clock,
   input  wire sb2seg_pkg::cell_ctrl_type ctrl,
   input  wire logic                      carry_in,
   input  wire sb2seg_pkg::digit_type     digit_in,
   output      logic                      carry_out,
   output      sb2seg_pkg::digit_type     digit_out
);
   import sb2seg_pkg::*;

   digit_type digit_ff;
   digit_type digit_in_w;
   digit_type adj;

   always_comb begin
      adj = (digit_ff >= 4'd5) ? digit_ff + 4'd3 : digit_ff;
   end

   always_comb begin
      priority if (ctrl.clear) begin
         digit_in_w = '0;
      end else if (ctrl.dabble) begin
         digit_in_w = {adj[2:0], carry_in};
      end else if (ctrl.shift_digit) begin
         digit_in_w = digit_in;
      end else begin
         digit_in_w = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_w;
   end

   assign carry_out = adj[3];
   assign digit_out = digit_ff;

endmodule

`default_nettype wire

[hdl/signed_binary_to_seven_segment.sv]
// Top level of the signed binary to seven-segment decoder.
// Instantiates a chain of sb2seg_cell digit cells; uses sb2seg_pkg.
//
// Each request word carries one signed integer; the block answers with one response word per
// significant decimal digit, most significant first, each with its segment pattern and position,
// a minus flag in tuser bit 0 and tlast on the units digit. Zero gives one word with the invalid
// flag (tuser bit 1) set. A word is taken only while the block is free: its magnitude is shifted
// through the chain of BCD cells, after which the digits are read out of the top cell one a
// cycle while the output is not stalled, leading zero cells first being skipped one a cycle, so a
// non-zero item occupies the block through the conversion and the readout of every cell, plus any
// output stall; a zero item skips the conversion. The number of cells is the digit count of
// 2^VALUE_BITS; the chain shifts one bit per cycle and sets the conversion time.
`default_nettype none

module signed_binary_to_seven_segment #(
   parameter int MAX_DIGITS = 10,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   input  wire logic [((VALUE_BITS+7)/8)*8-1:0]  req_tdata,  // value
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   output      logic [sb2seg_pkg::RSP_BITS-1:0]  rsp_tdata,  // segment_pattern, digit_index
   output      logic [sb2seg_pkg::USER_BITS-1:0] rsp_tuser,  // is_negative, invalid_input
   output      logic                             rsp_tlast   // last_digit
);
   import sb2seg_pkg::*;

   localparam int NUM_CELLS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int POS_W     = $clog2(NUM_CELLS);
   localparam int BCNT_W    = $clog2(VALUE_BITS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic                  zero_ff, zero_in;
   logic                  started_ff, started_in;
   logic [BCNT_W-1:0]     bcnt_ff, bcnt_in;
   logic [POS_W-1:0]      pos_ff, pos_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   seg_type               rsp_seg_ff, rsp_seg_in;
   logic [INDEX_BITS-1:0] rsp_idx_ff, rsp_idx_in;
   logic                  rsp_neg_ff, rsp_neg_in;
   logic                  rsp_inv_ff, rsp_inv_in;
   logic                  rsp_last_ff, rsp_last_in;

   cell_ctrl_type         ctrl;
   logic                  carry [NUM_CELLS];
   digit_type             digit [NUM_CELLS];
   digit_type             top_digit;

   logic [VALUE_BITS-1:0] raw;
   logic                  slot_free;
   logic                  skip;
   logic                  emit;
   logic                  accept;

   assign raw       = req_tdata[VALUE_BITS-1:0];
   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign top_digit = digit[NUM_CELLS-1];
   assign skip      = (state_ff == ST_OUT) && !zero_ff &&
                      ((!started_ff && top_digit == '0) || (5'(pos_ff) >= 5'(MAX_DIGITS)));
   assign emit      = (state_ff == ST_OUT) && !skip && slot_free;

   always_comb begin
      ctrl.clear       = accept;
      ctrl.dabble      = (state_ff == ST_CONV);
      ctrl.shift_digit = (state_ff == ST_OUT) && !zero_ff && (skip || emit);
   end

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      sb2seg_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .carry_in  ((i == 0) ? mag_ff[VALUE_BITS-1] : carry[(i == 0) ? 0 : i-1]),
         .digit_in  ((i == 0) ? digit_type'(0) : digit[(i == 0) ? 0 : i-1]),
         .carry_out (carry[i]),
         .digit_out (digit[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;
      started_in   = started_ff;
      bcnt_in      = bcnt_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_seg_in   = rsp_seg_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_neg_in   = rsp_neg_ff;
      rsp_inv_in   = rsp_inv_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in     = raw[VALUE_BITS-1];
               mag_in     = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
               zero_in    = (raw == '0);
               bcnt_in    = BCNT_W'(VALUE_BITS - 1);
               pos_in     = POS_W'(NUM_CELLS - 1);
               started_in = 1'b0;
               state_in   = (raw == '0) ? ST_OUT : ST_CONV;
            end
         end
         ST_CONV: begin
            mag_in  = {mag_ff[VALUE_BITS-2:0], 1'b0};
            bcnt_in = bcnt_ff - 1'b1;
            if (bcnt_ff == '0) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (zero_ff) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_seg_in   = '0;
                  rsp_idx_in   = '0;
                  rsp_neg_in   = 1'b0;
                  rsp_inv_in   = 1'b1;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (skip || emit) begin
               pos_in = pos_ff - 1'b1;
               if (top_digit != '0) begin
                  started_in = 1'b1;
               end
               if (emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_seg_in   = seg_of_digit(top_digit);
                  rsp_idx_in   = INDEX_BITS'(pos_ff);
                  rsp_neg_in   = neg_ff;
                  rsp_inv_in   = 1'b0;
                  rsp_last_in  = (pos_ff == '0);
                  if (pos_ff == '0) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      zero_ff     <= zero_in;
      started_ff  <= started_in;
      bcnt_ff     <= bcnt_in;
      pos_ff      <= pos_in;
      rsp_seg_ff  <= rsp_seg_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_neg_ff  <= rsp_neg_in;
      rsp_inv_ff  <= rsp_inv_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_BITS - SEG_BITS - INDEX_BITS)'(0), rsp_idx_ff, rsp_seg_ff};
   assign rsp_tuser  = {rsp_inv_ff, rsp_neg_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_invalid_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_inv_ff |-> rsp_last_ff && rsp_seg_ff == '0 && !rsp_neg_ff)
      else $error("invalid word not a lone blank final word");

   a_last_is_units: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff && !rsp_inv_ff |-> rsp_idx_ff == '0)
      else $error("final digit word not at position zero");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request taken while conversion pending");

endmodule

`default_nettype wire
